FILE: rtl/oers_pkg.sv
// ---------------------------------------------------------------------------
// oers_pkg: shared types and microprogram of the ODE stepper
// Operation and register codes, status codes and the step program that the
// sequencer walks through for one advance item.
// ---------------------------------------------------------------------------
package oers_pkg;

   // status codes of a result item
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_START = 2'd0;
   localparam logic [1:0] CSR_END   = 2'd1;
   localparam logic [1:0] CSR_INIT  = 2'd2;
   localparam logic [1:0] CSR_COUNT = 2'd3;

   // operations of the shared unit
   typedef enum logic [1:0] {
      OP_ADD,
      OP_MUL,
      OP_HALF,
      OP_DIV6
   } op_type;

   // operand / destination registers
   typedef enum logic [3:0] {
      R_ZERO,
      R_ONE,
      R_X,
      R_YE,
      R_YR,
      R_H,
      R_XM,
      R_XE,
      R_Y,
      R_T,
      R_S,
      R_K1,
      R_K2,
      R_K3
   } reg_type;

   typedef struct packed {
      op_type  op;
      reg_type dst;
      reg_type a;
      reg_type b;
   } instr_type;

   localparam int PC_BITS = 6;
   localparam logic [PC_BITS-1:0] PROG_LAST = 6'd41;

   // one step of euler and rk4
   function automatic instr_type prog(logic [PC_BITS-1:0] pc);
      instr_type i;
      case (pc)
         // euler: ye += h * (1+x)*ye*ye/2
         6'd0:  i = '{OP_MUL,  R_T,  R_YE, R_YE};
         6'd1:  i = '{OP_ADD,  R_S,  R_ONE, R_X};
         6'd2:  i = '{OP_MUL,  R_T,  R_S,  R_T};
         6'd3:  i = '{OP_HALF, R_T,  R_T,  R_ZERO};
         6'd4:  i = '{OP_MUL,  R_T,  R_T,  R_H};
         6'd5:  i = '{OP_ADD,  R_YE, R_YE, R_T};
         // midpoint and end of the step
         6'd6:  i = '{OP_HALF, R_XM, R_H,  R_ZERO};
         6'd7:  i = '{OP_ADD,  R_XM, R_X,  R_XM};
         6'd8:  i = '{OP_ADD,  R_XE, R_X,  R_H};
         // k1
         6'd9:  i = '{OP_MUL,  R_T,  R_YR, R_YR};
         6'd10: i = '{OP_ADD,  R_S,  R_ONE, R_X};
         6'd11: i = '{OP_MUL,  R_T,  R_S,  R_T};
         6'd12: i = '{OP_HALF, R_T,  R_T,  R_ZERO};
         6'd13: i = '{OP_MUL,  R_K1, R_H,  R_T};
         // k2
         6'd14: i = '{OP_HALF, R_Y,  R_K1, R_ZERO};
         6'd15: i = '{OP_ADD,  R_Y,  R_YR, R_Y};
         6'd16: i = '{OP_MUL,  R_T,  R_Y,  R_Y};
         6'd17: i = '{OP_ADD,  R_S,  R_ONE, R_XM};
         6'd18: i = '{OP_MUL,  R_T,  R_S,  R_T};
         6'd19: i = '{OP_HALF, R_T,  R_T,  R_ZERO};
         6'd20: i = '{OP_MUL,  R_K2, R_H,  R_T};
         // k3
         6'd21: i = '{OP_HALF, R_Y,  R_K2, R_ZERO};
         6'd22: i = '{OP_ADD,  R_Y,  R_YR, R_Y};
         6'd23: i = '{OP_MUL,  R_T,  R_Y,  R_Y};
         6'd24: i = '{OP_ADD,  R_S,  R_ONE, R_XM};
         6'd25: i = '{OP_MUL,  R_T,  R_S,  R_T};
         6'd26: i = '{OP_HALF, R_T,  R_T,  R_ZERO};
         6'd27: i = '{OP_MUL,  R_K3, R_H,  R_T};
         // k4, left in t
         6'd28: i = '{OP_ADD,  R_Y,  R_YR, R_K3};
         6'd29: i = '{OP_MUL,  R_T,  R_Y,  R_Y};
         6'd30: i = '{OP_ADD,  R_S,  R_ONE, R_XE};
         6'd31: i = '{OP_MUL,  R_T,  R_S,  R_T};
         6'd32: i = '{OP_HALF, R_T,  R_T,  R_ZERO};
         6'd33: i = '{OP_MUL,  R_T,  R_H,  R_T};
         // weighted sum, divide by six, update
         6'd34: i = '{OP_ADD,  R_K2, R_K2, R_K2};
         6'd35: i = '{OP_ADD,  R_K1, R_K1, R_K2};
         6'd36: i = '{OP_ADD,  R_K3, R_K3, R_K3};
         6'd37: i = '{OP_ADD,  R_K1, R_K1, R_K3};
         6'd38: i = '{OP_ADD,  R_K1, R_K1, R_T};
         6'd39: i = '{OP_DIV6, R_K1, R_K1, R_ZERO};
         6'd40: i = '{OP_ADD,  R_YR, R_YR, R_K1};
         6'd41: i = '{OP_ADD,  R_X,  R_XE, R_ZERO};
         default: i = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
      endcase
      return i;
   endfunction

endpackage

FILE: rtl/ode_euler_rk4_stepper.sv
// ---------------------------------------------------------------------------
// ode_euler_rk4_stepper: fixed-point euler and rk4 stepper
// Integrates dy/dx = (1+x)*y*y/2 with forward euler and classical rk4 side
// by side, one step per advance item, under a microcoded sequencer.
// ---------------------------------------------------------------------------
// A restart item (req_restart = 1) loads x, both y estimates and the step
// size h = (end - start) / step_count and returns the initial row; an
// invalid interval goes straight to the done state, a valid one first
// waits for the bit-serial divider. An advance item runs a 42-instruction
// program through one shared unit: 26 saturating adds and halvings and 16
// passes through the shared multiplier (15 products plus the division by
// six done as a reciprocal product), on the default Q16.16 word. Advances
// that take no step go straight to the done state. The block takes no
// item while one is in work; a finished row waits in the output register,
// and a row that cannot enter it holds the input off.
module ode_euler_rk4_stepper #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_x_value,
   output logic signed [31:0] rsp_euler_value,
   output logic signed [31:0] rsp_runge_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_final_row,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int W  = WORD_BITS;
   localparam int OW = (W > 32) ? W : 32;
   localparam int EW = OW + 1;
   localparam int DW = (W > 33) ? W : 33;
   localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
   localparam logic ONE_SAT = (FRAC_BITS > W - 2);
   localparam logic [W-1:0] ONE_W =
      ONE_SAT ? MAXW : ({{(W-1){1'b0}}, 1'b1} << FRAC_BITS);
   // ceil(2^W / 3): magnitude * RECIP6 >> (W+1) is the magnitude / 6
   localparam logic [W:0] RECIP_WIDE =
      ({1'b1, {W{1'b0}}} + (W+1)'(2)) / (W+1)'(3);
   localparam logic [W-1:0] RECIP6 = RECIP_WIDE[W-1:0];

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDIV,
      S_ISSUE,
      S_WAIT,
      S_DONE
   } state_type;

   // saturating add, overflow flag on top
   function automatic logic [W:0] sat_add(logic [W-1:0] p, logic [W-1:0] q);
      logic [W:0] s;
      s = {p[W-1], p} + {q[W-1], q};
      if (s[W] != s[W-1]) begin
         return {1'b1, s[W] ? MINW : MAXW};
      end
      return {1'b0, s[W-1:0]};
   endfunction

   // halve toward zero
   function automatic logic [W-1:0] halve(logic [W-1:0] p);
      logic [W-1:0] s;
      s = p + {{(W-1){1'b0}}, p[W-1]};
      return {s[W-1], s[W-1:1]};
   endfunction

   // load a 32-bit register value into the word, saturating
   function automatic logic [W:0] clamp_cfg(logic [31:0] v);
      logic [EW-1:0] ve;
      ve = EW'(signed'(v));
      if (ve[EW-1:W-1] != {(EW-W+1){ve[W-1]}}) begin
         return {1'b1, v[31] ? MINW : MAXW};
      end
      return {1'b0, ve[W-1:0]};
   endfunction

   function automatic logic [31:0] to_out(logic [W-1:0] v);
      logic [OW-1:0] t;
      t = OW'(signed'(v));
      return t[31:0];
   endfunction

   // configuration registers
   logic [31:0] istart_ff, iend_ff, iinit_ff;
   logic [15:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         istart_ff <= 32'd0;
         iend_ff   <= 32'd65536;
         iinit_ff  <= 32'd0;
         count_ff  <= 16'd10;
      end else if (csr_write_en) begin
         case (csr_index)
            oers_pkg::CSR_START: istart_ff <= csr_data;
            oers_pkg::CSR_END:   iend_ff   <= csr_data;
            oers_pkg::CSR_INIT:  iinit_ff  <= csr_data;
            oers_pkg::CSR_COUNT: count_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // sequencer and working registers
   state_type state_ff, state_in;
   logic [oers_pkg::PC_BITS-1:0] pc_ff, pc_in;
   logic [W-1:0] x_ff, x_in, ye_ff, ye_in, yr_ff, yr_in, h_ff, h_in;
   logic [W-1:0] xm_ff, xm_in, xe_ff, xe_in, y_ff, y_in, t_ff, t_in;
   logic [W-1:0] s_ff, s_in, k1_ff, k1_in, k2_ff, k2_in, k3_ff, k3_in;
   logic [15:0]  steps_ff, steps_in;
   logic         ovs_ff, ovs_in;
   logic         armed_ff, armed_in;
   logic [1:0]   pst_ff, pst_in;
   logic         plast_ff, plast_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rx_ff, rx_in, re_ff, re_in, rr_ff, rr_in;
   logic [1:0]   rst_ff, rst_in;
   logic         rlast_ff, rlast_in;

   // shared unit ports
   logic          mul_start, mul_done, mul_ovf, mul_recip;
   logic [W-1:0]  mul_res, mul_b;
   logic          div_start, div_done;
   logic [DW-1:0] div_dvd, div_q;
   logic [15:0]   div_dvs;

   oers_pkg::instr_type ins;
   logic [W-1:0] opa, opb;

   assign ins = oers_pkg::prog(pc_ff);

   function automatic logic [W-1:0] pick(oers_pkg::reg_type r, logic [W-1:0] vx,
         logic [W-1:0] vye, logic [W-1:0] vyr, logic [W-1:0] vh, logic [W-1:0] vxm,
         logic [W-1:0] vxe, logic [W-1:0] vy, logic [W-1:0] vt, logic [W-1:0] vs,
         logic [W-1:0] vk1, logic [W-1:0] vk2, logic [W-1:0] vk3);
      logic [W-1:0] v;
      case (r)
         oers_pkg::R_ONE: v = ONE_W;
         oers_pkg::R_X:   v = vx;
         oers_pkg::R_YE:  v = vye;
         oers_pkg::R_YR:  v = vyr;
         oers_pkg::R_H:   v = vh;
         oers_pkg::R_XM:  v = vxm;
         oers_pkg::R_XE:  v = vxe;
         oers_pkg::R_Y:   v = vy;
         oers_pkg::R_T:   v = vt;
         oers_pkg::R_S:   v = vs;
         oers_pkg::R_K1:  v = vk1;
         oers_pkg::R_K2:  v = vk2;
         oers_pkg::R_K3:  v = vk3;
         default:         v = '0;
      endcase
      return v;
   endfunction

   // operand select
   assign opa = pick(ins.a, x_ff, ye_ff, yr_ff, h_ff, xm_ff, xe_ff, y_ff, t_ff, s_ff,
                     k1_ff, k2_ff, k3_ff);
   assign opb = pick(ins.b, x_ff, ye_ff, yr_ff, h_ff, xm_ff, xe_ff, y_ff, t_ff, s_ff,
                     k1_ff, k2_ff, k3_ff);

   // division by six runs as a product with the reciprocal
   assign mul_recip = (ins.op == oers_pkg::OP_DIV6);
   assign mul_b     = mul_recip ? RECIP6 : opb;

   oers_mul #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (opa),
      .b      (mul_b),
      .recip  (mul_recip),
      .done   (mul_done),
      .result (mul_res),
      .ovf    (mul_ovf)
   );

   oers_div #(
      .DIV_BITS(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      logic [W:0]    sum;
      logic [W:0]    cx, cy;
      logic [32:0]   span;
      logic          wr_en;
      logic [W-1:0]  wr_val;
      logic          adv;
      logic          ov_add;
      logic [15:0]   steps_nx;

      state_in     = state_ff;
      pc_in        = pc_ff;
      x_in         = x_ff;
      ye_in        = ye_ff;
      yr_in        = yr_ff;
      h_in         = h_ff;
      xm_in        = xm_ff;
      xe_in        = xe_ff;
      y_in         = y_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      k3_in        = k3_ff;
      steps_in     = steps_ff;
      ovs_in       = ovs_ff;
      armed_in     = armed_ff;
      pst_in       = pst_ff;
      plast_in     = plast_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rx_in        = rx_ff;
      re_in        = re_ff;
      rr_in        = rr_ff;
      rst_in       = rst_ff;
      rlast_in     = rlast_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      cx           = clamp_cfg(istart_ff);
      cy           = clamp_cfg(iinit_ff);
      span         = {iend_ff[31], iend_ff} - {istart_ff[31], istart_ff};
      div_dvd      = DW'(span);
      div_dvs      = count_ff;
      sum          = sat_add(opa, opb);
      wr_en        = 1'b0;
      wr_val       = '0;
      adv          = 1'b0;
      ov_add       = sum[W] || (ONE_SAT && (ins.a == oers_pkg::R_ONE ||
                                            ins.b == oers_pkg::R_ONE));
      steps_nx     = steps_ff + 16'd1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  // load start row, then find h
                  x_in     = cx[W-1:0];
                  ye_in    = cy[W-1:0];
                  yr_in    = cy[W-1:0];
                  steps_in = '0;
                  ovs_in   = cx[W] | cy[W];
                  plast_in = 1'b0;
                  if ($signed(iend_ff) <= $signed(istart_ff) || count_ff == '0) begin
                     armed_in = 1'b0;
                     h_in     = '0;
                     pst_in   = oers_pkg::ST_BAD;
                     state_in = S_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_HDIV;
                  end
               end else if (!armed_ff) begin
                  pst_in   = oers_pkg::ST_BAD;
                  plast_in = 1'b0;
                  state_in = S_DONE;
               end else if (steps_ff >= count_ff) begin
                  pst_in   = oers_pkg::ST_DONE;
                  plast_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  pc_in    = '0;
                  state_in = S_ISSUE;
               end
            end
         end
         S_HDIV: begin
            if (div_done) begin
               if (div_q[DW-1:W-1] != '0) begin
                  h_in   = MAXW;
                  ovs_in = 1'b1;
                  pst_in = oers_pkg::ST_OVF;
               end else begin
                  h_in   = div_q[W-1:0];
                  pst_in = ovs_ff ? oers_pkg::ST_OVF : oers_pkg::ST_OK;
               end
               armed_in = 1'b1;
               state_in = S_DONE;
            end
         end
         S_ISSUE: begin
            case (ins.op)
               oers_pkg::OP_ADD: begin
                  wr_en  = 1'b1;
                  wr_val = sum[W-1:0];
                  ovs_in = ovs_ff | ov_add;
                  adv    = 1'b1;
               end
               oers_pkg::OP_HALF: begin
                  wr_en  = 1'b1;
                  wr_val = halve(opa);
                  adv    = 1'b1;
               end
               oers_pkg::OP_MUL, oers_pkg::OP_DIV6: begin
                  mul_start = 1'b1;
                  state_in  = S_WAIT;
               end
               default: ;
            endcase
         end
         S_WAIT: begin
            if (mul_done) begin
               wr_en  = 1'b1;
               wr_val = mul_res;
               ovs_in = ovs_ff | mul_ovf;
               adv    = 1'b1;
            end
         end
         S_DONE: begin
            // hand the row to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rx_in        = to_out(x_ff);
               re_in        = to_out(ye_ff);
               rr_in        = to_out(yr_ff);
               rst_in       = pst_ff;
               rlast_in     = plast_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // register file write
      if (wr_en) begin
         case (ins.dst)
            oers_pkg::R_X:  x_in  = wr_val;
            oers_pkg::R_YE: ye_in = wr_val;
            oers_pkg::R_YR: yr_in = wr_val;
            oers_pkg::R_H:  h_in  = wr_val;
            oers_pkg::R_XM: xm_in = wr_val;
            oers_pkg::R_XE: xe_in = wr_val;
            oers_pkg::R_Y:  y_in  = wr_val;
            oers_pkg::R_T:  t_in  = wr_val;
            oers_pkg::R_S:  s_in  = wr_val;
            oers_pkg::R_K1: k1_in = wr_val;
            oers_pkg::R_K2: k2_in = wr_val;
            oers_pkg::R_K3: k3_in = wr_val;
            default: ;
         endcase
      end

      // next instruction or end of step
      if (adv) begin
         if (pc_ff == oers_pkg::PROG_LAST) begin
            steps_in = steps_nx;
            pst_in   = ovs_in ? oers_pkg::ST_OVF : oers_pkg::ST_OK;
            plast_in = steps_nx >= count_ff;
            state_in = S_DONE;
         end else begin
            pc_in    = pc_ff + 1'b1;
            state_in = S_ISSUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         x_ff         <= '0;
         ye_ff        <= '0;
         yr_ff        <= '0;
         h_ff         <= '0;
         steps_ff     <= '0;
         ovs_ff       <= 1'b0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         x_ff         <= x_in;
         ye_ff        <= ye_in;
         yr_ff        <= yr_in;
         h_ff         <= h_in;
         steps_ff     <= steps_in;
         ovs_ff       <= ovs_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xm_ff    <= xm_in;
      xe_ff    <= xe_in;
      y_ff     <= y_in;
      t_ff     <= t_in;
      s_ff     <= s_in;
      k1_ff    <= k1_in;
      k2_ff    <= k2_in;
      k3_ff    <= k3_in;
      pst_ff   <= pst_in;
      plast_ff <= plast_in;
      rx_ff    <= rx_in;
      re_ff    <= re_in;
      rr_ff    <= rr_in;
      rst_ff   <= rst_in;
      rlast_ff <= rlast_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_value     = rx_ff;
   assign rsp_euler_value = re_ff;
   assign rsp_runge_value = rr_ff;
   assign rsp_status      = rst_ff;
   assign rsp_final_row   = rlast_ff;

endmodule

FILE: rtl/oers_mul.sv
// ---------------------------------------------------------------------------
// oers_mul: multi-cycle saturating fixed-point multiplier
// Multiplies magnitudes 16 bits of b per cycle, drops the fraction bits
// (toward zero), applies the sign and saturates to the word range. With
// recip set, b holds a reciprocal and the product is shifted down by
// WORD_BITS+1 instead, giving an exact quotient by a constant.
// ---------------------------------------------------------------------------
module oers_mul #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] a,
   input  logic [WORD_BITS-1:0] b,
   input  logic                 recip,
   output logic                 done,
   output logic [WORD_BITS-1:0] result,
   output logic                 ovf
);

   localparam int W   = WORD_BITS;
   localparam int NCH = (W + 15) / 16;
   localparam int PB  = NCH * 16;
   localparam int PW  = 2 * W;
   localparam int CW  = $clog2(NCH + 1);
   localparam int RSH = W + 1;
   localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PB-1:0] bsh_ff, bsh_in;
   logic [W-1:0]  am_ff, am_in;
   logic          neg_ff, neg_in;
   logic          recip_ff, recip_in;
   logic          done_ff, done_in;
   logic [W-1:0]  result_ff, result_in;
   logic          ovf_ff, ovf_in;

   // truncating shift and saturation of the finished product
   logic [PW-1:0] shifted;
   logic [PW-1:0] lim;
   logic [W-1:0]  rlow;
   assign shifted = recip_ff ? (acc_ff >> RSH) : (acc_ff >> FRAC_BITS);
   assign lim     = PW'(MAXW) + PW'(neg_ff);
   assign rlow    = shifted[W-1:0];

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      bsh_in    = bsh_ff;
      am_in     = am_ff;
      neg_in    = neg_ff;
      recip_in  = recip_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      ovf_in    = ovf_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CW'(NCH);
         acc_in   = '0;
         am_in    = a[W-1] ? (~a + 1'b1) : a;
         bsh_in   = PB'(b[W-1] ? (~b + 1'b1) : b);
         neg_in   = a[W-1] ^ b[W-1];
         recip_in = recip;
      end else if (busy_ff && cnt_ff != '0) begin
         // one 16-bit digit of b per cycle, most significant first
         acc_in = (acc_ff << 16) + PW'(am_ff * bsh_ff[PB-1 -: 16]);
         bsh_in = bsh_ff << 16;
         cnt_in = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         busy_in = 1'b0;
         done_in = 1'b1;
         if (shifted > lim) begin
            ovf_in    = 1'b1;
            result_in = neg_ff ? MINW : MAXW;
         end else begin
            ovf_in    = 1'b0;
            result_in = neg_ff ? (~rlow + 1'b1) : rlow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      bsh_ff    <= bsh_in;
      am_ff     <= am_in;
      neg_ff    <= neg_in;
      recip_ff  <= recip_in;
      result_ff <= result_in;
      ovf_ff    <= ovf_in;
   end

   assign done   = done_ff;
   assign result = result_ff;
   assign ovf    = ovf_ff;

endmodule

FILE: rtl/oers_div.sv
// ---------------------------------------------------------------------------
// oers_div: bit-serial unsigned divider
// Restoring division of a wide dividend by a 16-bit divisor, one quotient
// bit per cycle.
// ---------------------------------------------------------------------------
module oers_div #(
   parameter int DIV_BITS = 33
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [15:0]         divisor,
   output logic                done,
   output logic [DIV_BITS-1:0] quotient
);

   localparam int DW = DIV_BITS;
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] q_ff, q_in;
   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   dvs_ff, dvs_in;
   logic          done_ff, done_in;

   // trial subtract of the shifted remainder
   logic [16:0] rem_sh;
   logic [16:0] diff;
   logic        ge;
   assign rem_sh = {rem_ff, q_ff[DW-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[15:0] : rem_sh[15:0];
         q_in   = {q_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: rtl/oers_checker.sv
// ---------------------------------------------------------------------------
// oers_checker: port-level checks for the ODE stepper
// Watches the item handshakes and the result fields over time.
// ---------------------------------------------------------------------------
module oers_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_x_value,
   input logic signed [31:0] rsp_euler_value,
   input logic signed [31:0] rsp_runge_value,
   input logic [1:0]         rsp_status,
   input logic               rsp_final_row
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // ready is low in the cycle after an item is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after an item was accepted");

   // a final row never carries the invalid status
   a_final_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_row) |-> rsp_status != oers_pkg::ST_BAD)
      else $error("final row with invalid status");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_x_value) &&
                                     $stable(rsp_euler_value) &&
                                     $stable(rsp_runge_value) &&
                                     $stable(rsp_status) && $stable(rsp_final_row)))
      else $error("result changed while stalled");

endmodule

bind ode_euler_rk4_stepper oers_checker u_oers_checker (.*);
